/* rtl/cfl2_pkg.sv */
// ----------------------------------------------------------------------------
// cfl2_pkg
// Shared types and constants for the chroma fold and L2 normalize block.
// ----------------------------------------------------------------------------
`default_nettype none

package cfl2_pkg;

   localparam int unsigned FRAC_BITS   = 15;
   localparam int unsigned Q15_ONE     = 32768;
   localparam int unsigned CSR_W       = 6;
   localparam int unsigned OUT_W       = 16;
   localparam int unsigned IN_W        = 16;
   localparam logic [CSR_W-1:0] SIZE_RESET = 6'd12;

   typedef struct packed {
      logic load;
      logic sq_step;
      logic sqrt_init;
      logic sqrt_step;
      logic div_init;
      logic div_step;
      logic emit;
      logic next_k;
      logic clear;
   } cfl2_cmd_type;

   typedef struct packed {
      logic sq_done;
      logic sqrt_done;
      logic div_done;
      logic out_free;
      logic k_last;
   } cfl2_sts_type;

endpackage

`default_nettype wire

/* rtl/chroma_fold_l2_normalize.sv */
// ----------------------------------------------------------------------------
// chroma_fold_l2_normalize
// Folds a semitone frame into a chroma vector and scales it to unit L2 norm.
// ----------------------------------------------------------------------------
// req_* carries one Q8.8 bin per word, req_last_bin closes the frame. Bins are
// taken one per cycle while the block is loading. After the last bin, req_stall
// stays high while the block forms the sum of squares (one squarer),
// the integer root (one bit per cycle) and then, per chroma bin, a bit-serial
// divide before the word is loaded into the rsp_* output register. S =
// octave_size, clamped to 1..MAX_OCTAVE_SIZE.
// Frames in error or with zero energy skip the divides.
// rsp_stall holds the output word and pauses the sequencer; req_stall stays
// high until the last word of the frame is in the output register.
// csr_wr_en writes octave_size and clears the frame in progress; write only
// while idle. Reset sets octave_size to 12 and clears accumulators and rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module chroma_fold_l2_normalize #(
   parameter int unsigned MAX_OCTAVE_SIZE = 32,
   parameter int unsigned MAX_OCTAVES     = 16,
   parameter int unsigned SAMPLE_WIDTH    = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [cfl2_pkg::CSR_W-1:0]  csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [cfl2_pkg::IN_W-1:0]   req_bin_value,
   input  wire logic                        req_last_bin,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [cfl2_pkg::OUT_W-1:0]       rsp_chroma_value,
   output logic                             rsp_last_chroma,
   output logic                             rsp_frame_error
);
   import cfl2_pkg::*;

   cfl2_cmd_type cmd;
   cfl2_sts_type sts;

   cfl2_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_last_bin (req_last_bin),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   cfl2_dp #(
      .MAX_OCTAVE_SIZE (MAX_OCTAVE_SIZE),
      .MAX_OCTAVES     (MAX_OCTAVES),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_bin_value    (req_bin_value),
      .req_last_bin     (req_last_bin),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_chroma_value (rsp_chroma_value),
      .rsp_last_chroma  (rsp_last_chroma),
      .rsp_frame_error  (rsp_frame_error),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire

/* rtl/cfl2_ctrl.sv */
// ----------------------------------------------------------------------------
// cfl2_ctrl
// Sequencer: bin load, sum of squares, square root, per-bin divide and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl2_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_last_bin,
   output logic                       req_stall,
   input  wire cfl2_pkg::cfl2_sts_type sts,
   output cfl2_pkg::cfl2_cmd_type     cmd
);
   import cfl2_pkg::*;

   localparam logic [2:0] ST_LOAD  = 3'd0;
   localparam logic [2:0] ST_SUMSQ = 3'd1;
   localparam logic [2:0] ST_SQRT  = 3'd2;
   localparam logic [2:0] ST_DIVI  = 3'd3;
   localparam logic [2:0] ST_DIVS  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != ST_LOAD);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_bin) state_in = ST_SUMSQ;
            end
         end
         ST_SUMSQ: begin
            cmd.sq_step = 1'b1;
            if (sts.sq_done) begin
               cmd.sqrt_init = 1'b1;
               state_in      = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_done) state_in = ST_DIVI;
         end
         ST_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.k_last) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_LOAD;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = ST_DIVI;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

/* rtl/cfl2_dp.sv */
// ----------------------------------------------------------------------------
// cfl2_dp
// Accumulators, squarer, bit-serial square root and divider, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl2_dp #(
   parameter int unsigned MAX_OCTAVE_SIZE = 32,
   parameter int unsigned MAX_OCTAVES     = 16,
   parameter int unsigned SAMPLE_WIDTH    = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [cfl2_pkg::CSR_W-1:0]  csr_wr_data,
   input  wire logic [cfl2_pkg::IN_W-1:0]   req_bin_value,
   input  wire logic                        req_last_bin,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [cfl2_pkg::OUT_W-1:0]       rsp_chroma_value,
   output logic                             rsp_last_chroma,
   output logic                             rsp_frame_error,
   input  wire cfl2_pkg::cfl2_cmd_type      cmd,
   output cfl2_pkg::cfl2_sts_type           sts
);
   import cfl2_pkg::*;

   localparam int unsigned VW     = (SAMPLE_WIDTH < IN_W) ? SAMPLE_WIDTH : IN_W;
   localparam int unsigned ACC_W  = VW + $clog2(MAX_OCTAVES + 1);
   localparam int unsigned POS_W  = (MAX_OCTAVE_SIZE > 1) ? $clog2(MAX_OCTAVE_SIZE) : 1;
   localparam int unsigned CNT_W  = $clog2(MAX_OCTAVE_SIZE + 1);
   localparam int unsigned OCT_W  = $clog2(MAX_OCTAVES + 1);
   localparam int unsigned PROD_W = 2 * ACC_W;
   localparam int unsigned SUM_W  = PROD_W + $clog2(MAX_OCTAVE_SIZE) + 1;
   localparam int unsigned ROOT_W = (SUM_W + 1) / 2;
   localparam int unsigned RAD_W  = 2 * ROOT_W;
   localparam int unsigned NUM_W  = ACC_W + FRAC_BITS + 1;
   localparam int unsigned SQC_W  = $clog2(ROOT_W + 1);
   localparam int unsigned DVC_W  = $clog2(NUM_W + 1);

   logic [CSR_W-1:0]  size_ff;
   logic [CNT_W-1:0]  s_eff;
   logic [ACC_W-1:0]  acc_ff [MAX_OCTAVE_SIZE];
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [OCT_W-1:0]  oct_ff, oct_in;
   logic              ovf_ff, ovf_in;
   logic              err_ff;
   logic              full;
   logic              wrap;
   logic              wipe;
   logic [CNT_W-1:0]  k_ff;
   logic [ACC_W-1:0]  acc_k;
   logic [PROD_W-1:0] prod_ff;
   logic              prod_vld_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] sqrem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SQC_W-1:0]  sqc_ff;
   logic [ROOT_W+1:0] sq_r, sq_t;
   logic [NUM_W-1:0]  num_ff;
   logic [ROOT_W-1:0] dvrem_ff;
   logic [DVC_W-1:0]  dvc_ff;
   logic [ROOT_W:0]   dv_r;
   logic              skip;
   logic [OUT_W-1:0]  q_val;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  value_ff;
   logic              last_ff, ferr_ff;

   always_comb begin
      if (size_ff == '0)
         s_eff = CNT_W'(1);
      else if ({1'b0, size_ff} > (CSR_W+1)'(MAX_OCTAVE_SIZE))
         s_eff = CNT_W'(MAX_OCTAVE_SIZE);
      else
         s_eff = CNT_W'(size_ff);
   end

   assign wipe  = reset || csr_wr_en || cmd.clear;
   assign full  = (oct_ff == OCT_W'(MAX_OCTAVES));
   assign wrap  = ((CNT_W'(pos_ff) + CNT_W'(1)) == s_eff);
   assign acc_k = acc_ff[k_ff[POS_W-1:0]];

   always_comb begin
      pos_in = pos_ff;
      oct_in = oct_ff;
      ovf_in = ovf_ff;
      if (full) begin
         ovf_in = 1'b1;
      end else if (wrap) begin
         pos_in = '0;
         oct_in = oct_ff + OCT_W'(1);
      end else begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) size_ff <= SIZE_RESET;
      else if (csr_wr_en) size_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (wipe) begin
         for (int i = 0; i < MAX_OCTAVE_SIZE; i++) acc_ff[i] <= '0;
         pos_ff <= '0;
         oct_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.load) begin
         if (!full)
            acc_ff[pos_ff] <= acc_ff[pos_ff] + ACC_W'(req_bin_value[VW-1:0]);
         pos_ff <= pos_in;
         oct_ff <= oct_in;
         ovf_ff <= ovf_in;
      end
   end

   // sum of squares, one accumulator per cycle
   always_ff @(posedge clock) begin
      if (cmd.load && req_last_bin) begin
         err_ff      <= ovf_in || (pos_in != '0);
         k_ff        <= '0;
         sum_ff      <= '0;
         prod_vld_ff <= 1'b0;
      end else if (cmd.sqrt_init) begin
         k_ff <= '0;
      end else if (cmd.sq_step) begin
         if (prod_vld_ff) sum_ff <= sum_ff + SUM_W'(prod_ff);
         if (k_ff < s_eff) begin
            prod_ff     <= acc_k * acc_k;
            prod_vld_ff <= 1'b1;
            k_ff        <= k_ff + CNT_W'(1);
         end else begin
            prod_vld_ff <= 1'b0;
         end
      end else if (cmd.next_k) begin
         k_ff <= k_ff + CNT_W'(1);
      end
   end

   // square root, one result bit per cycle
   assign sq_r = {sqrem_ff, rad_ff[RAD_W-1 -: 2]};
   assign sq_t = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_init) begin
         rad_ff   <= RAD_W'(sum_ff);
         sqrem_ff <= '0;
         root_ff  <= '0;
         sqc_ff   <= SQC_W'(ROOT_W);
      end else if (cmd.sqrt_step && sqc_ff != '0) begin
         rad_ff <= rad_ff << 2;
         sqc_ff <= sqc_ff - SQC_W'(1);
         if (sq_r >= sq_t) begin
            sqrem_ff <= ROOT_W'(sq_r - sq_t);
            root_ff  <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            sqrem_ff <= ROOT_W'(sq_r);
            root_ff  <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // restoring divide, quotient shifts into the numerator register
   assign dv_r = {dvrem_ff, num_ff[NUM_W-1]};
   assign skip = err_ff || (root_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff   <= (NUM_W'(acc_k) << FRAC_BITS) + NUM_W'(root_ff >> 1);
         dvrem_ff <= '0;
         dvc_ff   <= DVC_W'(NUM_W);
      end else if (cmd.div_step && dvc_ff != '0) begin
         dvc_ff <= dvc_ff - DVC_W'(1);
         if (dv_r >= {1'b0, root_ff}) begin
            dvrem_ff <= ROOT_W'(dv_r - {1'b0, root_ff});
            num_ff   <= {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            dvrem_ff <= ROOT_W'(dv_r);
            num_ff   <= {num_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (skip)
         q_val = '0;
      else if (num_ff > NUM_W'(Q15_ONE))
         q_val = OUT_W'(Q15_ONE);
      else
         q_val = num_ff[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         value_ff <= q_val;
         last_ff  <= (k_ff == s_eff - CNT_W'(1));
         ferr_ff  <= err_ff;
      end
   end

   assign sts.sq_done   = (k_ff == s_eff) && !prod_vld_ff;
   assign sts.sqrt_done = (sqc_ff == '0);
   assign sts.div_done  = skip || (dvc_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;
   assign sts.k_last    = (k_ff == s_eff - CNT_W'(1));

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_chroma_value = value_ff;
   assign rsp_last_chroma  = last_ff;
   assign rsp_frame_error  = ferr_ff;

endmodule

`default_nettype wire

/* rtl/cfl2_checker.sv */
// ----------------------------------------------------------------------------
// cfl2_checker
// Port-level checks for the chroma fold and L2 normalize block.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl2_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [cfl2_pkg::OUT_W-1:0] rsp_chroma_value,
   input wire logic                       rsp_last_chroma,
   input wire logic                       rsp_frame_error
);
   import cfl2_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_chroma_value)
         && $stable(rsp_last_chroma) && $stable(rsp_frame_error))
      else $error("stalled word changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chroma_value <= OUT_W'(Q15_ONE))
      else $error("chroma value above one");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_error |-> rsp_chroma_value == '0)
      else $error("error word with nonzero value");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("word valid after reset");

endmodule

bind chroma_fold_l2_normalize cfl2_checker u_cfl2_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_chroma_value (rsp_chroma_value),
   .rsp_last_chroma  (rsp_last_chroma),
   .rsp_frame_error  (rsp_frame_error)
);

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for chroma_fold_l2_normalize. Drives semitone frames bin by bin,
// predicts the folded, L2-normalized chroma words and compares every output
// word field by field, with random idle and stall on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import cfl2_pkg::*;

   localparam int unsigned MAX_SIZE = 32;
   localparam int unsigned MAX_OCT  = 16;

   typedef struct packed {
      logic [OUT_W-1:0] chroma;
      logic             last;
      logic             err;
   } chroma_word_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [IN_W-1:0]  req_bin_value = '0;
   logic             req_last_bin = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [OUT_W-1:0] rsp_chroma_value;
   logic             rsp_last_chroma;
   logic             rsp_frame_error;

   chroma_word_type chroma_q[$];
   int              fail_count = 0;
   bit              no_idle = 1'b0;

   logic [CSR_W-1:0] size_reg;
   logic [19:0]      acc[MAX_SIZE];
   int unsigned      pos, octaves;
   bit               overflow;

   chroma_fold_l2_normalize i_dut (.*);

   always #5 clock = ~clock;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   function automatic int unsigned eff_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return size_reg;
   endfunction

   function automatic void clear_frame();
      foreach (acc[k]) acc[k] = '0;
      pos = 0;
      octaves = 0;
      overflow = 1'b0;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // fold one bin; at frame end queue the normalized chroma words
   function automatic void fold_bin(input logic [IN_W-1:0] v, input logic last);
      int unsigned s = eff_size();
      bit err;
      longint unsigned sq = 0, root, q;
      chroma_word_type w;
      if (octaves >= MAX_OCT) begin
         overflow = 1'b1;
      end else begin
         if (pos >= s) pos = 0;
         acc[pos] += v;
         pos++;
         if (pos >= s) begin
            pos = 0;
            octaves++;
         end
      end
      if (!last) return;
      err = overflow || pos != 0;
      for (int k = 0; k < s; k++) sq += longint'(acc[k]) * longint'(acc[k]);
      root = int_sqrt(sq);
      for (int k = 0; k < s; k++) begin
         q = 0;
         if (!err && root != 0) begin
            q = ((longint'(acc[k]) << FRAC_BITS) + (root >> 1)) / root;
            if (q > Q15_ONE) q = Q15_ONE;
         end
         w.chroma = q[OUT_W-1:0];
         w.last = (k == s - 1);
         w.err = err;
         chroma_q.push_back(w);
      end
      clear_frame();
   endfunction

   function automatic bit idle_now();
      return !no_idle && $urandom_range(99) < 21;
   endfunction

   task automatic send_bin(input logic [IN_W-1:0] v, input logic last);
      while (idle_now()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_bin_value <= v;
      req_last_bin <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fold_bin(v, last);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (chroma_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_size(input logic [CSR_W-1:0] v);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_reg = v;
      clear_frame();
   endtask

   task automatic send_frame(input int unsigned n, input int unsigned maxv);
      for (int i = 0; i < n; i++)
         send_bin(IN_W'($urandom_range(maxv)), i == n - 1);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (chroma_q.size() == 0) begin
               report("unexpected word", rsp_chroma_value, 0);
            end else begin
               chroma_word_type w;
               w = chroma_q.pop_front();
               if (rsp_chroma_value !== w.chroma) report("chroma", rsp_chroma_value, w.chroma);
               if (rsp_last_chroma !== w.last) report("last", rsp_last_chroma, w.last);
               if (rsp_frame_error !== w.err) report("error", rsp_frame_error, w.err);
            end
         end
         rsp_stall <= idle_now();
      end
   end

   task automatic test_directed();
      write_size(6'd3);
      send_bin(16'hFFFF, 1'b0); send_bin(16'h0000, 1'b0); send_bin(16'h0001, 1'b1);
      send_bin(0, 1'b0); send_bin(0, 1'b0); send_bin(0, 1'b1);   // zero energy
      send_bin(16'h1234, 1'b0); send_bin(16'h00FF, 1'b1);        // partial octave
      send_bin(16'h8000, 1'b1);                                  // short frame
      write_size(6'd0);                                          // acts as one
      send_bin(16'h5555, 1'b0); send_bin(16'hAAAA, 1'b1);
      write_size(6'd63);                                         // clamps to max
      send_frame(32, 65535);
      write_size(6'd1);
      send_frame(18, 65535);                                     // store overflow
   endtask

   task automatic test_random();
      int unsigned s, n;
      for (int f = 0; f < 20; f++) begin
         if (f % 8 == 0) write_size(CSR_W'($urandom_range(1, 8)));
         no_idle = (f >= 12 && f < 16);
         s = eff_size();
         case ($urandom_range(9))
            0: n = $urandom_range(1, 3 * s);
            1: n = s * MAX_OCT + $urandom_range(1, 3);
            default: n = s * $urandom_range(1, s > 8 ? 1 : 4);
         endcase
         send_frame(n, $urandom_range(1) ? 65535 : 255);
         if (f == 10) wait_drain();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      size_reg = SIZE_RESET;
      clear_frame();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      wait_drain();
      if (fail_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #50ms;
      $display("tb: errors");
      $finish;
   end

endmodule

/* filelist.f */
rtl/cfl2_pkg.sv
rtl/cfl2_ctrl.sv
rtl/cfl2_dp.sv
rtl/chroma_fold_l2_normalize.sv
rtl/cfl2_checker.sv
test/tb.sv
